// ----- rtl/slt_pkg.sv -----
// ----------------------------------------------------------------------------
// slt_pkg
// Shared types and constants of the sorted list table: operation codes,
// engine states and the layout of one result request.
// ----------------------------------------------------------------------------
package slt_pkg;

    localparam int DEF_CAPACITY   = 32;
    localparam int DEF_VALUE_BITS = 32;

    localparam int OP_W    = 3;
    localparam int POS_W   = 5;
    localparam int ITEM_W  = 32;
    localparam int COUNT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_DELETE    = 3'd1,
        OP_FIND      = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_LIST_ASC  = 3'd4,
        OP_LIST_DESC = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_PUT
    } state_t;

    typedef struct packed {
        logic               ok;
        logic [POS_W-1:0]   position;
        logic [ITEM_W-1:0]  item_value;
        logic [COUNT_W-1:0] entry_count;
        logic               last_item;
    } result_t;

endpackage

// ----- rtl/sorted_list_table.sv -----
// ----------------------------------------------------------------------------
// sorted_list_table
// Bounded multiset of signed values kept in ascending order in one memory.
// ----------------------------------------------------------------------------
// Input channel s_*: one request of op and value. Result channel m_*: one
// result per request, or one per stored entry for the two list operations,
// with m_last_item marking the final one.
// Clear, unknown codes, operations on an empty store and an insert into a
// full store answer from the count alone: the result is loaded into the
// result register as the request is taken.
// Other operations walk the value memory, one entry per read step and
// compare and write-back step, since the memory has a single read port
// with a registered output:
//   find / delete : each entry up to the match (delete: to the end)
//   insert        : each entry greater or equal, shifted up; then placed
//                   above a smaller entry, or at the head in a head step
//   list          : each entry listed
// A new request is taken only when the engine is idle and the result
// register is free or being emptied.
// Reset clears the entry count and the handshake state; the memory is not
// cleared, entries above the count are never read. While the receiver
// stalls, the result register holds and the engine waits in its compare or
// head-write step.
// ----------------------------------------------------------------------------
module sorted_list_table
    import slt_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_op,
    input  logic signed [ITEM_W-1:0]  s_value,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ok,
    output logic [POS_W-1:0]          m_position,
    output logic signed [ITEM_W-1:0]  m_item_value,
    output logic [COUNT_W-1:0]        m_entry_count,
    output logic                      m_last_item
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    state_t                state_reg, state_next;
    op_t                   op_reg, op_next;
    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         del_pos_reg, del_pos_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic                  found_reg, found_next;

    logic [VALUE_BITS-1:0] mem [CAPACITY];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  mem_rd;
    logic                  mem_we;
    logic [IW-1:0]         mem_wr_addr;
    logic [VALUE_BITS-1:0] mem_wr_data;

    logic                  out_free;
    logic                  out_load;
    result_t               res;

    logic [VALUE_BITS-1:0] in_val;
    logic [IW-1:0]         idx_inc, idx_dec, last_idx;
    logic [CW-1:0]         cnt_inc, cnt_dec;
    logic                  has_room, at_last, is_less, is_equal, list_last;

    function automatic result_t make_res(input logic ok, input logic [IW-1:0] pos,
                                         input logic [VALUE_BITS-1:0] val,
                                         input logic [CW-1:0] cnt, input logic last);
        result_t r;
        r.ok          = ok;
        r.position    = POS_W'(pos);
        r.item_value  = ITEM_W'(val);
        r.entry_count = COUNT_W'(cnt);
        r.last_item   = last;
        return r;
    endfunction

    assign in_val   = VALUE_BITS'(s_value);
    assign idx_inc  = idx_reg + IW'(1);
    assign idx_dec  = idx_reg - IW'(1);
    assign cnt_inc  = cnt_reg + CW'(1);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign last_idx = IW'(cnt_dec);
    assign has_room = cnt_reg < CW'(CAPACITY);
    assign at_last  = CW'(idx_reg) == cnt_dec;
    assign is_less  = $signed(rd_data_reg) < $signed(val_reg);
    assign is_equal = rd_data_reg == val_reg;
    assign list_last = (op_reg == OP_LIST_ASC) ? at_last : (idx_reg == '0);
    assign mem_rd   = state_reg == ST_RD;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        del_pos_reg <= del_pos_next;
        val_reg     <= val_next;
    end

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        del_pos_next = del_pos_reg;
        cnt_next     = cnt_reg;
        val_next     = val_reg;
        found_next   = found_reg;
        mem_we       = 1'b0;
        mem_wr_addr  = idx_inc;
        mem_wr_data  = val_reg;
        out_load     = 1'b0;
        res          = '0;
        s_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    val_next   = in_val;
                    op_next    = op_t'(s_op);
                    found_next = 1'b0;
                    unique case (s_op)
                        OP_INSERT: begin
                            if (!has_room) begin
                                out_load = 1'b1;
                                res      = make_res(1'b0, '0, in_val, cnt_reg, 1'b1);
                            end else if (cnt_reg == '0) begin
                                mem_we      = 1'b1;
                                mem_wr_addr = '0;
                                mem_wr_data = in_val;
                                cnt_next    = cnt_inc;
                                out_load    = 1'b1;
                                res         = make_res(1'b1, '0, in_val, cnt_inc, 1'b1);
                            end else begin
                                idx_next   = last_idx;
                                state_next = ST_RD;
                            end
                        end
                        OP_DELETE, OP_FIND: begin
                            if (cnt_reg == '0) begin
                                out_load = 1'b1;
                                res      = make_res(1'b0, '0, in_val, cnt_reg, 1'b1);
                            end else begin
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                        end
                        OP_CLEAR: begin
                            cnt_next = '0;
                            out_load = 1'b1;
                            res      = make_res(1'b1, '0, '0, '0, 1'b1);
                        end
                        OP_LIST_ASC, OP_LIST_DESC: begin
                            if (cnt_reg == '0) begin
                                out_load = 1'b1;
                                res      = make_res(1'b0, '0, '0, '0, 1'b1);
                            end else begin
                                idx_next   = (s_op == OP_LIST_ASC) ? '0 : last_idx;
                                state_next = ST_RD;
                            end
                        end
                        default: begin
                            out_load = 1'b1;
                            res      = make_res(1'b0, '0, '0, cnt_reg, 1'b1);
                        end
                    endcase
                end
            end

            ST_RD: begin
                state_next = ST_EX;
            end

            ST_EX: begin
                unique case (op_reg)
                    OP_INSERT: begin
                        if (!is_less) begin
                            mem_we      = 1'b1;
                            mem_wr_data = rd_data_reg;
                            if (idx_reg == '0) begin
                                state_next = ST_PUT;
                            end else begin
                                idx_next   = idx_dec;
                                state_next = ST_RD;
                            end
                        end else if (out_free) begin
                            mem_we     = 1'b1;
                            cnt_next   = cnt_inc;
                            out_load   = 1'b1;
                            res        = make_res(1'b1, idx_inc, val_reg, cnt_inc, 1'b1);
                            state_next = ST_IDLE;
                        end
                    end
                    OP_DELETE, OP_FIND: begin
                        if (found_reg) begin
                            if (!at_last || out_free) begin
                                mem_we      = 1'b1;
                                mem_wr_addr = idx_dec;
                                mem_wr_data = rd_data_reg;
                                if (at_last) begin
                                    cnt_next   = cnt_dec;
                                    out_load   = 1'b1;
                                    res        = make_res(1'b1, del_pos_reg, val_reg,
                                                          cnt_dec, 1'b1);
                                    state_next = ST_IDLE;
                                end else begin
                                    idx_next   = idx_inc;
                                    state_next = ST_RD;
                                end
                            end
                        end else if (is_equal && op_reg == OP_FIND) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res        = make_res(1'b1, idx_reg, val_reg, cnt_reg, 1'b1);
                                state_next = ST_IDLE;
                            end
                        end else if (is_equal) begin
                            if (!at_last) begin
                                found_next   = 1'b1;
                                del_pos_next = idx_reg;
                                idx_next     = idx_inc;
                                state_next   = ST_RD;
                            end else if (out_free) begin
                                cnt_next   = cnt_dec;
                                out_load   = 1'b1;
                                res        = make_res(1'b1, idx_reg, val_reg, cnt_dec, 1'b1);
                                state_next = ST_IDLE;
                            end
                        end else if (at_last) begin
                            if (out_free) begin
                                out_load   = 1'b1;
                                res        = make_res(1'b0, '0, val_reg, cnt_reg, 1'b1);
                                state_next = ST_IDLE;
                            end
                        end else begin
                            idx_next   = idx_inc;
                            state_next = ST_RD;
                        end
                    end
                    OP_LIST_ASC, OP_LIST_DESC: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            res      = make_res(1'b1, idx_reg, rd_data_reg, cnt_reg, list_last);
                            if (list_last) begin
                                state_next = ST_IDLE;
                            end else begin
                                idx_next   = (op_reg == OP_LIST_ASC) ? idx_inc : idx_dec;
                                state_next = ST_RD;
                            end
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_PUT: begin
                if (out_free) begin
                    mem_we      = 1'b1;
                    mem_wr_addr = '0;
                    cnt_next    = cnt_inc;
                    out_load    = 1'b1;
                    res         = make_res(1'b1, '0, val_reg, cnt_inc, 1'b1);
                    state_next  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    slt_out_reg u_out_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (out_load),
        .res           (res),
        .out_free      (out_free),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ok          (m_ok),
        .m_position    (m_position),
        .m_item_value  (m_item_value),
        .m_entry_count (m_entry_count),
        .m_last_item   (m_last_item)
    );

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid || m_ready))
        else $error("result register overwritten while held");

    a_read_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> (CW'(idx_reg) < cnt_reg))
        else $error("memory read above entry count");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_op == OP_CLEAR) |=> (cnt_reg == '0))
        else $error("clear left entries behind");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("request taken while engine busy");

endmodule

// ----- rtl/slt_out_reg.sv -----
// ----------------------------------------------------------------------------
// slt_out_reg
// Result register: holds one result request until the receiver takes it.
// ----------------------------------------------------------------------------
module slt_out_reg
    import slt_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  result_t                   res,
    output logic                      out_free,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_ok,
    output logic [POS_W-1:0]          m_position,
    output logic signed [ITEM_W-1:0]  m_item_value,
    output logic [COUNT_W-1:0]        m_entry_count,
    output logic                      m_last_item
);

    logic    valid_reg;
    result_t res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

    assign out_free      = !valid_reg || m_ready;
    assign m_valid       = valid_reg;
    assign m_ok          = res_reg.ok;
    assign m_position    = res_reg.position;
    assign m_item_value  = res_reg.item_value;
    assign m_entry_count = res_reg.entry_count;
    assign m_last_item   = res_reg.last_item;

endmodule
